FILE: hdl/ffha_pkg.sv
`default_nettype none
package ffha_pkg;

   typedef struct packed {
      logic [15:0] start;
      logic [16:0] payload;
      logic        free;
   } entry_type;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_NOMEM = 2'd1;
   localparam logic [1:0] STATUS_BAD   = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE, ST_START, ST_RD, ST_CHK, ST_NOHIT, ST_HIT, ST_SH_RD, ST_SH_WR,
      ST_SPLIT, ST_CLAIM, ST_NX_RD, ST_NX_CHK, ST_MERGE, ST_CP_RD, ST_CP_WR, ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_START, OP_SCAN_RD, OP_SCAN_CHK, OP_NOHIT, OP_HIT, OP_SH_RD,
      OP_SH_WR, OP_SPLIT, OP_CLAIM, OP_NX_RD, OP_NX_CHK, OP_MERGE, OP_CP_RD, OP_CP_WR
   } op_type;

   typedef struct packed {
      op_type op;
      logic   emit;
   } cmd_type;

   typedef struct packed {
      logic is_free;
      logic bad_size;
      logic empty;
      logic match;
      logic last;
      logic split_ok;
      logic shift_more;
      logic has_next;
      logic merge_more;
      logic cp_more;
      logic rsp_free;
   } stat_type;

   function automatic logic [15:0] sat16(input logic [17:0] v);
      return (v > 18'h0FFFF) ? 16'hFFFF : v[15:0];
   endfunction

endpackage
`default_nettype wire

FILE: hdl/first_fit_heap_allocator.sv
// the result is loaded into the output register once that register is free
// a request scans table entries; entries are shifted up on a split or moved down after a merge
// one item at a time: the next is accepted in the idle state, after the previous result is loaded
// the next item is taken while the previous result waits in the output register
// synchronous reset empties the table, clears arena top and sets the limit to 65536
`default_nettype none
module first_fit_heap_allocator import ffha_pkg::*; #(
   parameter int unsigned HEAP_BYTES   = 65536,
   parameter int unsigned HEADER_BYTES = 32,
   parameter int unsigned MAX_CHUNKS   = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic        req_action,
   input  wire logic [15:0] req_request_size,
   input  wire logic [15:0] req_block_address,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [1:0]  rsp_status,
   output      logic [15:0] rsp_payload_address,
   output      logic [15:0] rsp_chunk_bytes,
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [16:0] csr_arena_limit
);

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   ffha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ffha_dp #(
      .HEAP_BYTES   (HEAP_BYTES),
      .HEADER_BYTES (HEADER_BYTES),
      .MAX_CHUNKS   (MAX_CHUNKS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_action          (req_action),
      .req_request_size    (req_request_size),
      .req_block_address   (req_block_address),
      .csr_valid           (csr_valid),
      .csr_arena_limit     (csr_arena_limit),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_payload_address (rsp_payload_address),
      .rsp_chunk_bytes     (rsp_chunk_bytes)
   );

endmodule
`default_nettype wire

FILE: hdl/ffha_ram.sv
`default_nettype none
module ffha_ram #(
   parameter int unsigned WIDTH = 34,
   parameter int unsigned DEPTH = 32
) (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  wire logic [WIDTH-1:0]                 wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]         rd_addr,
   output      logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: hdl/ffha_ctrl.sv
`default_nettype none
module ffha_ctrl import ffha_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output      logic     req_ready,
   input  wire stat_type stat,
   output      cmd_type  cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_START;
         ST_START: begin
            priority if (stat.bad_size) state_in = ST_DONE;
            else if (stat.empty)        state_in = ST_NOHIT;
            else                        state_in = ST_RD;
         end
         ST_RD:     state_in = ST_CHK;
         ST_CHK: begin
            priority if (stat.match) state_in = ST_HIT;
            else if (stat.last)      state_in = ST_NOHIT;
            else                     state_in = ST_RD;
         end
         ST_NOHIT:  state_in = ST_DONE;
         ST_HIT: begin
            priority if (stat.is_free) state_in = stat.has_next ? ST_NX_RD : ST_MERGE;
            else if (stat.split_ok)    state_in = stat.shift_more ? ST_SH_RD : ST_SPLIT;
            else                       state_in = ST_CLAIM;
         end
         ST_SH_RD:  state_in = ST_SH_WR;
         ST_SH_WR:  state_in = stat.shift_more ? ST_SH_RD : ST_SPLIT;
         ST_SPLIT:  state_in = ST_CLAIM;
         ST_CLAIM:  state_in = ST_DONE;
         ST_NX_RD:  state_in = ST_NX_CHK;
         ST_NX_CHK: state_in = ST_MERGE;
         ST_MERGE:  state_in = stat.merge_more ? ST_CP_RD : ST_DONE;
         ST_CP_RD:  state_in = ST_CP_WR;
         ST_CP_WR:  state_in = stat.cp_more ? ST_CP_RD : ST_DONE;
         ST_DONE:   if (stat.rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd.op    = OP_NONE;
      cmd.emit  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = OP_LOAD;
         end
         ST_START:  cmd.op = OP_START;
         ST_RD:     cmd.op = OP_SCAN_RD;
         ST_CHK:    cmd.op = OP_SCAN_CHK;
         ST_NOHIT:  cmd.op = OP_NOHIT;
         ST_HIT:    cmd.op = OP_HIT;
         ST_SH_RD:  cmd.op = OP_SH_RD;
         ST_SH_WR:  cmd.op = OP_SH_WR;
         ST_SPLIT:  cmd.op = OP_SPLIT;
         ST_CLAIM:  cmd.op = OP_CLAIM;
         ST_NX_RD:  cmd.op = OP_NX_RD;
         ST_NX_CHK: cmd.op = OP_NX_CHK;
         ST_MERGE:  cmd.op = OP_MERGE;
         ST_CP_RD:  cmd.op = OP_CP_RD;
         ST_CP_WR:  cmd.op = OP_CP_WR;
         ST_DONE:   cmd.emit = stat.rsp_free;
         default:   cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/ffha_dp.sv
`default_nettype none
module ffha_dp import ffha_pkg::*; #(
   parameter int unsigned HEAP_BYTES   = 65536,
   parameter int unsigned HEADER_BYTES = 32,
   parameter int unsigned MAX_CHUNKS   = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output      stat_type    stat,
   input  wire logic        req_action,
   input  wire logic [15:0] req_request_size,
   input  wire logic [15:0] req_block_address,
   input  wire logic        csr_valid,
   input  wire logic [16:0] csr_arena_limit,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [1:0]  rsp_status,
   output      logic [15:0] rsp_payload_address,
   output      logic [15:0] rsp_chunk_bytes
);

   localparam int unsigned CW  = $clog2(MAX_CHUNKS + 1);
   localparam int unsigned IW  = $clog2(MAX_CHUNKS);
   localparam int unsigned CAP = (HEAP_BYTES < 65536) ? HEAP_BYTES : 65536;
   localparam logic [17:0]   HDR     = 18'(HEADER_BYTES);
   localparam logic [16:0]   LIM_CAP = 17'(CAP);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_CHUNKS);
   localparam logic [CW-1:0] ONE     = CW'(1);

   logic [CW-1:0] count_ff, count_in;
   logic [16:0]   top_ff, top_in;
   logic [16:0]   limit_ff, limit_in;
   logic          act_ff, act_in;
   logic [15:0]   size_ff, size_in;
   logic [15:0]   addr_ff, addr_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   entry_type     cur_ff, cur_in;
   entry_type     prev_ff, prev_in;
   entry_type     next_ff, next_in;
   logic          next_ok_ff, next_ok_in;
   logic          split_ff, split_in;
   logic [1:0]    res_status_ff, res_status_in;
   logic [15:0]   res_addr_ff, res_addr_in;
   logic [15:0]   res_bytes_ff, res_bytes_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [15:0]   rsp_addr_ff, rsp_addr_in;
   logic [15:0]   rsp_bytes_ff, rsp_bytes_in;

   entry_type     rd_entry;
   logic          wr_en;
   logic [CW-1:0] wr_idx;
   logic [CW-1:0] rd_idx;
   entry_type     wr_entry;

   logic [CW-1:0] idx_nx, ptr_dn, ptr_up, m_idx, new_count;
   logic [16:0]   lim;
   logic          match, split_ok, over, full, pm, nm;
   logic [1:0]    drop;
   logic [15:0]   m_start;
   logic [17:0]   total, append_need, split_start, split_pay, cur_hdr, top_hdr;
   logic [16:0]   claim_pay;

   assign idx_nx    = idx_ff + ONE;
   assign ptr_dn    = ptr_ff - ONE;
   assign ptr_up    = ptr_ff + ONE;
   assign lim       = (limit_ff < LIM_CAP) ? limit_ff : LIM_CAP;
   assign match     = act_ff ? (!rd_entry.free && ({2'b0, rd_entry.start} + HDR == {2'b0, addr_ff}))
                             : (rd_entry.free && (rd_entry.payload >= {1'b0, size_ff}));
   assign split_ok  = ({1'b0, cur_ff.payload} > ({2'b0, size_ff} + HDR)) && (count_ff < MAX_CNT);
   assign append_need = {1'b0, top_ff} + HDR + {2'b0, size_ff};
   assign over      = append_need > {1'b0, lim};
   assign full      = count_ff >= MAX_CNT;
   assign pm        = (idx_ff != '0) && prev_ff.free;
   assign nm        = next_ok_ff && next_ff.free;
   assign drop      = {1'b0, pm} + {1'b0, nm};
   assign m_idx     = pm ? (idx_ff - ONE) : idx_ff;
   assign m_start   = pm ? prev_ff.start : cur_ff.start;
   assign total     = {1'b0, cur_ff.payload}
                    + (pm ? ({1'b0, prev_ff.payload} + HDR) : 18'd0)
                    + (nm ? ({1'b0, next_ff.payload} + HDR) : 18'd0);
   assign new_count = count_ff - CW'(drop);
   assign split_start = {2'b0, cur_ff.start} + HDR + {2'b0, size_ff};
   assign split_pay = {1'b0, cur_ff.payload} - {2'b0, size_ff} - HDR;
   assign claim_pay = split_ff ? {1'b0, size_ff} : cur_ff.payload;
   assign cur_hdr   = {2'b0, cur_ff.start} + HDR;
   assign top_hdr   = {1'b0, top_ff} + HDR;

   always_comb begin
      stat.is_free    = act_ff;
      stat.bad_size   = !act_ff && (size_ff == '0);
      stat.empty      = (count_ff == '0);
      stat.match      = match;
      stat.last       = (idx_nx == count_ff);
      stat.split_ok   = split_ok;
      stat.shift_more = (cmd.op == OP_HIT) ? (count_ff > idx_nx) : (ptr_dn > idx_nx);
      stat.has_next   = (idx_nx < count_ff);
      stat.merge_more = (drop != 2'd0) && ((m_idx + ONE) < new_count);
      stat.cp_more    = (ptr_up < count_ff);
      stat.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      count_in      = count_ff;
      top_in        = top_ff;
      limit_in      = csr_valid ? csr_arena_limit : limit_ff;
      act_in        = act_ff;
      size_in       = size_ff;
      addr_in       = addr_ff;
      idx_in        = idx_ff;
      ptr_in        = ptr_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      next_in       = next_ff;
      next_ok_in    = next_ok_ff;
      split_in      = split_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      res_bytes_in  = res_bytes_ff;
      wr_en         = 1'b0;
      wr_idx        = idx_ff;
      wr_entry      = rd_entry;
      rd_idx        = idx_ff;
      unique case (cmd.op)
         OP_LOAD: begin
            act_in        = req_action;
            size_in       = req_request_size;
            addr_in       = req_block_address;
            idx_in        = '0;
            res_status_in = STATUS_OK;
            res_addr_in   = '0;
            res_bytes_in  = '0;
         end
         OP_START: begin
            if (stat.bad_size) res_status_in = STATUS_BAD;
         end
         OP_SCAN_RD: rd_idx = idx_ff;
         OP_SCAN_CHK: begin
            if (match) begin
               cur_in = rd_entry;
            end else begin
               prev_in = rd_entry;
               idx_in  = idx_nx;
            end
         end
         OP_NOHIT: begin
            if (act_ff) begin
               res_status_in = STATUS_BAD;
            end else if (full || over) begin
               res_status_in = STATUS_NOMEM;
            end else begin
               wr_en            = 1'b1;
               wr_idx           = count_ff;
               wr_entry.start   = top_ff[15:0];
               wr_entry.payload = {1'b0, size_ff};
               wr_entry.free    = 1'b0;
               count_in         = count_ff + ONE;
               top_in           = append_need[16:0];
               res_addr_in      = sat16(top_hdr);
               res_bytes_in     = size_ff;
            end
         end
         OP_HIT: begin
            split_in   = split_ok;
            ptr_in     = count_ff;
            next_ok_in = 1'b0;
         end
         OP_SH_RD: rd_idx = ptr_dn;
         OP_SH_WR: begin
            wr_en  = 1'b1;
            wr_idx = ptr_ff;
            ptr_in = ptr_dn;
         end
         OP_SPLIT: begin
            wr_en            = 1'b1;
            wr_idx           = idx_nx;
            wr_entry.start   = split_start[15:0];
            wr_entry.payload = split_pay[16:0];
            wr_entry.free    = 1'b1;
         end
         OP_CLAIM: begin
            wr_en            = 1'b1;
            wr_idx           = idx_ff;
            wr_entry.start   = cur_ff.start;
            wr_entry.payload = claim_pay;
            wr_entry.free    = 1'b0;
            if (split_ff) count_in = count_ff + ONE;
            res_addr_in      = sat16(cur_hdr);
            res_bytes_in     = sat16({1'b0, claim_pay});
         end
         OP_NX_RD: rd_idx = idx_nx;
         OP_NX_CHK: begin
            next_in    = rd_entry;
            next_ok_in = 1'b1;
         end
         OP_MERGE: begin
            wr_en            = 1'b1;
            wr_idx           = m_idx;
            wr_entry.start   = m_start;
            wr_entry.payload = total[16:0];
            wr_entry.free    = 1'b1;
            count_in         = new_count;
            ptr_in           = m_idx + ONE;
            res_addr_in      = sat16({2'b0, m_start} + HDR);
            res_bytes_in     = sat16(total);
         end
         OP_CP_RD: rd_idx = ptr_ff + CW'(drop);
         OP_CP_WR: begin
            wr_en  = 1'b1;
            wr_idx = ptr_ff;
            ptr_in = ptr_up;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_bytes_in  = rsp_bytes_ff;
      if (cmd.emit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_addr_in   = res_addr_ff;
         rsp_bytes_in  = res_bytes_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         top_ff       <= '0;
         limit_ff     <= 17'h10000;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         top_ff       <= top_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      size_ff       <= size_in;
      addr_ff       <= addr_in;
      idx_ff        <= idx_in;
      ptr_ff        <= ptr_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      next_ff       <= next_in;
      next_ok_ff    <= next_ok_in;
      split_ff      <= split_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      res_bytes_ff  <= res_bytes_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_bytes_ff  <= rsp_bytes_in;
   end

   ffha_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (MAX_CHUNKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_idx[IW-1:0]),
      .wr_data (wr_entry),
      .rd_addr (rd_idx[IW-1:0]),
      .rd_data (rd_entry)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_payload_address = rsp_addr_ff;
   assign rsp_chunk_bytes     = rsp_bytes_ff;

endmodule
`default_nettype wire

FILE: hdl/ffha_checker.sv
`default_nettype none
module ffha_checker import ffha_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_status,
   input wire logic [15:0] rsp_payload_address,
   input wire logic [15:0] rsp_chunk_bytes
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped before accept");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |->
         (rsp_payload_address == 16'd0) && (rsp_chunk_bytes == 16'd0))
      else $error("error item carries nonzero fields");

   a_ok_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_OK) |-> (rsp_chunk_bytes != 16'd0))
      else $error("granted chunk has zero size");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_OK) || (rsp_status == STATUS_NOMEM)
                    || (rsp_status == STATUS_BAD))
      else $error("undefined status code");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (.*);
`default_nettype wire
